### rtl/gsig_pkg.sv
// ----------------------------------------------------------------------------
// Gather source index generator package
// Shared types, constants and the small radix-16 divide step used by the
// dimension sections.
// ----------------------------------------------------------------------------
package gsig_pkg;

    localparam int NUM_DIMS    = 4;
    localparam int DIV_STAGES  = 8;   // four quotient bits per stage, 32 bits
    localparam int DIM_STAGES  = DIV_STAGES + 1;
    localparam int TAIL_STAGES = 4;
    localparam int LATENCY     = NUM_DIMS * DIM_STAGES + TAIL_STAGES;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_OUT_SIZES     = 3'd0,
        REG_IN_SIZES      = 3'd1,
        REG_STRIDES_OUTER = 3'd2,
        REG_STRIDES_INNER = 3'd3,
        REG_INDEXED_MASK  = 3'd4,
        REG_INDEX_LENGTH  = 3'd5,
        REG_RANGE_FIRST   = 3'd6,
        REG_RANGE_LAST    = 3'd7
    } cfg_reg_t;

    localparam logic CMD_MAP  = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef struct packed {
        logic [63:0] out_sizes;
        logic [63:0] in_sizes;
        logic [63:0] strides_outer;
        logic [63:0] strides_inner;
        logic [3:0]  indexed_mask;
        logic [10:0] index_length;
        logic [3:0]  range_first;
        logic [3:0]  range_last;
    } gsig_cfg_t;

    // One transaction as it travels down the pipeline.
    typedef struct packed {
        logic              load;
        logic [31:0]       row;
        logic [31:0]       acc;
        logic [31:0]       prod;
        logic [31:0]       pos;
        logic              pos_set;
        logic signed [3:0] odim;
        logic [1:0]        sel;
        logic [9:0]        epos;
        logic [31:0]       eval;
    } gsig_item_t;

    // Select the 16-bit output size that the output dimension pointer names.
    function automatic logic [15:0] out_size(input logic [63:0] sizes,
                                             input logic signed [3:0] odim);
        logic [1:0] od;
        od = odim[3] ? 2'd0 : odim[1:0];
        return sizes[16*od +: 16];
    endfunction

    // Four steps of restoring division: returns {remainder, quotient bits}.
    function automatic logic [19:0] div4(input logic [15:0] rem,
                                         input logic [3:0]  bits,
                                         input logic [15:0] dvs);
        logic [16:0] sh;
        logic [15:0] r;
        logic [3:0]  q;
        r = rem;
        q = '0;
        for (int k = 3; k >= 0; k--)
        begin
            sh = {r, bits[k]};
            if (sh >= {1'b0, dvs})
            begin
                r    = 16'(sh - {1'b0, dvs});
                q[k] = 1'b1;
            end
            else
            begin
                r = sh[15:0];
            end
        end
        return {r, q};
    endfunction

endpackage

### rtl/gsig_table.sv
// ----------------------------------------------------------------------------
// Gather source index generator index tables
// Four synchronous index tables, one write port shared by the loads and one
// common read address for the four tables, read data registered.
// ----------------------------------------------------------------------------
module gsig_table
    import gsig_pkg::*;
#(
    parameter int INDEX_DEPTH = 1024,
    parameter int AW          = 10
)
(
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [1:0]                  wr_sel,
    input  logic [AW-1:0]               wr_addr,
    input  logic [31:0]                 wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [NUM_DIMS-1:0][31:0]   rd_data
);

    for (genvar t = 0; t < NUM_DIMS; t++)
    begin : g_tbl
        logic [31:0] mem [0:INDEX_DEPTH-1];

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_sel == 2'(t)))
            begin
                mem[wr_addr] <= wr_data;
            end
            if (rd_en)
            begin
                rd_data[t] <= mem[rd_addr];
            end
        end
    end

endmodule

### rtl/gsig_dim.sv
// ----------------------------------------------------------------------------
// Gather source index generator dimension section
// Eight pipelined divide stages (row by output size and by index length)
// followed by one stage that settles the coordinate and the row for the
// next dimension.
// ----------------------------------------------------------------------------
module gsig_dim
    import gsig_pkg::*;
#(
    parameter int DIM = 3
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  gsig_cfg_t  cfg,
    input  logic       in_valid,
    input  gsig_item_t in_item,
    output logic       out_valid,
    output gsig_item_t out_item
);

    typedef struct packed {
        logic [15:0] dvs_o;
        logic [15:0] rem_o;
        logic [15:0] rem_l;
        logic [31:0] q_o;
    } div_state_t;

    localparam logic signed [3:0] DIM_S = 4'(DIM);

    logic       vld_reg  [0:DIV_STAGES];
    gsig_item_t item_reg [0:DIV_STAGES];
    div_state_t div_reg  [0:DIV_STAGES-1];

    logic [15:0] len16;
    logic [31:0] stride;

    assign len16 = {5'b0, cfg.index_length};

    if (DIM < 2)
    begin : g_so
        assign stride = cfg.strides_outer[32*DIM +: 32];
    end
    else
    begin : g_si
        assign stride = cfg.strides_inner[32*(DIM-2) +: 32];
    end

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_stage
        gsig_item_t isrc;
        div_state_t dsrc;
        div_state_t dnext;
        logic       vsrc;
        logic [19:0] so;
        logic [19:0] sl;

        if (j == 0)
        begin : g_first
            always_comb
            begin
                isrc       = in_item;
                isrc.acc   = in_item.acc + in_item.prod;
                isrc.prod  = '0;
                dsrc       = '0;
                dsrc.dvs_o = out_size(cfg.out_sizes, in_item.odim);
            end
            assign vsrc = in_valid;
        end
        else
        begin : g_next
            assign isrc = item_reg[j-1];
            assign dsrc = div_reg[j-1];
            assign vsrc = vld_reg[j-1];
        end

        always_comb
        begin
            so          = div4(dsrc.rem_o, isrc.row[31-4*j -: 4], dsrc.dvs_o);
            sl          = div4(dsrc.rem_l, isrc.row[31-4*j -: 4], len16);
            dnext.dvs_o = dsrc.dvs_o;
            dnext.rem_o = so[19:4];
            dnext.rem_l = sl[19:4];
            dnext.q_o   = {dsrc.q_o[27:0], so[3:0]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else
            begin
                vld_reg[j] <= vsrc;
            end
        end

        always_ff @(posedge clk)
        begin
            item_reg[j] <= isrc;
            div_reg[j]  <= dnext;
        end
    end

    // Settle stage: quotient, remainder, shared entry position, product.
    gsig_item_t fin_next;
    gsig_item_t fin_src;
    div_state_t fin_div;
    logic [31:0] quo;
    logic [31:0] rem;
    logic [31:0] pos_calc;

    assign fin_src = item_reg[DIV_STAGES-1];
    assign fin_div = div_reg[DIV_STAGES-1];

    always_comb
    begin
        quo      = (fin_div.dvs_o == '0) ? '1 : fin_div.q_o;
        rem      = (fin_div.dvs_o == '0) ? fin_src.row : {16'b0, fin_div.rem_o};
        pos_calc = (len16 == '0) ? fin_src.row : {16'b0, fin_div.rem_l};
        fin_next = fin_src;
        if (cfg.indexed_mask[DIM])
        begin
            fin_next.prod = '0;
            if (!fin_src.pos_set)
            begin
                fin_next.pos     = pos_calc;
                fin_next.pos_set = 1'b1;
                fin_next.row     = quo;
            end
        end
        else
        begin
            fin_next.prod = 32'(rem * stride);
            fin_next.row  = quo;
        end
        if (!(($signed(cfg.range_first) < DIM_S) && (DIM_S <= $signed(cfg.range_last))))
        begin
            fin_next.odim = fin_src.odim - 4'sd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[DIV_STAGES] <= 1'b0;
        end
        else
        begin
            vld_reg[DIV_STAGES] <= vld_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg[DIV_STAGES] <= fin_next;
    end

    assign out_valid = vld_reg[DIV_STAGES];
    assign out_item  = item_reg[DIV_STAGES];

endmodule

### rtl/gather_source_index_generator_top.sv
// ----------------------------------------------------------------------------
// Gather source index generator
// Maps output rows of a tensor gather to source rows and holds the index
// tables that the indexed dimensions read.
// ----------------------------------------------------------------------------
// The block takes one transaction in every clock cycle: busy is never raised,
// so start may stay high for as long as the source has work. A map command
// returns its source_row, marked by a one-cycle done strobe, in order; a
// load command returns nothing. The pipeline holds the four dimension
// sections, each eight divide stages of four quotient bits plus one settle
// stage, and four tail stages: table read, negative-entry correction,
// stride multiply and sum. Loads write the index tables in the same
// pipeline stage in which maps read them, so every map sees exactly the
// loads accepted before it. The receiver must take done and source_row in
// the cycle they appear. Configuration is written through cfg_we,
// cfg_index and cfg_data and must only change while no transaction is in
// flight.
// ----------------------------------------------------------------------------
module gather_source_index_generator_top
    import gsig_pkg::*;
#(
    parameter int INDEX_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [31:0] out_row,
    input  logic [1:0]  table_sel,
    input  logic [9:0]  entry_pos,
    input  logic [31:0] entry_value,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output logic        done,
    output logic [31:0] source_row
);

    localparam int AW = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    gsig_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.out_sizes     <= 64'd281479271743489;
            cfg_reg.in_sizes      <= 64'd281479271743489;
            cfg_reg.strides_outer <= '0;
            cfg_reg.strides_inner <= '0;
            cfg_reg.indexed_mask  <= '0;
            cfg_reg.index_length  <= 11'd1;
            cfg_reg.range_first   <= 4'hF;
            cfg_reg.range_last    <= 4'hF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_OUT_SIZES:     cfg_reg.out_sizes     <= cfg_data;
                REG_IN_SIZES:      cfg_reg.in_sizes      <= cfg_data;
                REG_STRIDES_OUTER: cfg_reg.strides_outer <= cfg_data;
                REG_STRIDES_INNER: cfg_reg.strides_inner <= cfg_data;
                REG_INDEXED_MASK:  cfg_reg.indexed_mask  <= cfg_data[3:0];
                REG_INDEX_LENGTH:  cfg_reg.index_length  <= cfg_data[10:0];
                REG_RANGE_FIRST:   cfg_reg.range_first   <= cfg_data[3:0];
                REG_RANGE_LAST:    cfg_reg.range_last    <= cfg_data[3:0];
                default:           cfg_reg.range_last    <= cfg_reg.range_last;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Entry of a transaction: the dimension walk starts at dimension 3
    // with the output size pointer at 3 and nothing accumulated.
    // ------------------------------------------------------------------
    logic       accept;
    gsig_item_t entry_item;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        entry_item         = '0;
        entry_item.load    = (cmd == CMD_LOAD);
        entry_item.row     = out_row;
        entry_item.odim    = 4'sd3;
        entry_item.sel     = table_sel;
        entry_item.epos    = entry_pos;
        entry_item.eval    = entry_value;
    end

    // ------------------------------------------------------------------
    // Four dimension sections, innermost first.
    // ------------------------------------------------------------------
    logic       dv [0:NUM_DIMS];
    gsig_item_t di [0:NUM_DIMS];

    assign dv[0] = accept;
    assign di[0] = entry_item;

    for (genvar k = 0; k < NUM_DIMS; k++)
    begin : g_dim
        gsig_dim #(
            .DIM (NUM_DIMS - 1 - k)
        ) u_dim (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg       (cfg_reg),
            .in_valid  (dv[k]),
            .in_item   (di[k]),
            .out_valid (dv[k+1]),
            .out_item  (di[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Tail stage 1: table access. Maps read all four tables at the shared
    // position; loads write their entry here, so ordering with maps holds.
    // ------------------------------------------------------------------
    gsig_item_t              t_item;
    logic [31:0]             epos32;
    logic                    wr_en;
    logic                    rd_en;
    logic [NUM_DIMS-1:0][31:0] rd_data;

    assign t_item = di[NUM_DIMS];
    assign epos32 = {22'b0, t_item.epos};
    assign wr_en  = dv[NUM_DIMS] && t_item.load && (epos32 < 32'(INDEX_DEPTH));
    assign rd_en  = dv[NUM_DIMS] && !t_item.load;

    gsig_table #(
        .INDEX_DEPTH (INDEX_DEPTH),
        .AW          (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_sel  (t_item.sel),
        .wr_addr (epos32[AW-1:0]),
        .wr_data (t_item.eval),
        .rd_en   (rd_en),
        .rd_addr (t_item.pos[AW-1:0]),
        .rd_data (rd_data)
    );

    logic        s1_map_reg;
    logic        s1_pos_ok_reg;
    logic [31:0] s1_acc_reg;

    // Tail stage 2: positions past the table depth read as zero, and a
    // negative entry gets the dimension's input size added.
    logic                      s2_map_reg;
    logic [31:0]               s2_acc_reg;
    logic [NUM_DIMS-1:0][31:0] coord_next;
    logic [NUM_DIMS-1:0][31:0] coord_reg;

    // Tail stage 3: coordinate times stride for the indexed dimensions.
    logic                      s3_map_reg;
    logic [31:0]               s3_acc_reg;
    logic [NUM_DIMS-1:0][31:0] prod_next;
    logic [NUM_DIMS-1:0][31:0] prod_reg;
    logic [NUM_DIMS-1:0][31:0] strides;

    assign strides = {cfg_reg.strides_inner, cfg_reg.strides_outer};

    always_comb
    begin
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            coord_next[d] = s1_pos_ok_reg ? rd_data[d] : '0;
            if (coord_next[d][31])
            begin
                coord_next[d] = coord_next[d] + {16'b0, cfg_reg.in_sizes[16*d +: 16]};
            end
            prod_next[d] = cfg_reg.indexed_mask[d] ? 32'(coord_reg[d] * strides[d]) : '0;
        end
    end

    // Tail stage 4: sum of the running total and the indexed products.
    logic        done_reg;
    logic [31:0] source_row_reg;
    logic [31:0] sum_next;

    assign sum_next = (s3_acc_reg + prod_reg[0]) + (prod_reg[1] + prod_reg[2])
                    + prod_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_map_reg <= 1'b0;
            s2_map_reg <= 1'b0;
            s3_map_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_map_reg <= rd_en;
            s2_map_reg <= s1_map_reg;
            s3_map_reg <= s2_map_reg;
            done_reg   <= s3_map_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_acc_reg     <= t_item.acc + t_item.prod;
        s1_pos_ok_reg  <= t_item.pos < 32'(INDEX_DEPTH);
        s2_acc_reg     <= s1_acc_reg;
        coord_reg      <= coord_next;
        s3_acc_reg     <= s2_acc_reg;
        prod_reg       <= prod_next;
        source_row_reg <= sum_next;
    end

    assign done       = done_reg;
    assign source_row = source_row_reg;

endmodule

### rtl/gsig_checker.sv
// ----------------------------------------------------------------------------
// Gather source index generator port checker
// Watches the top level's ports: constant acceptance and the fixed latency
// from a map transaction to its result.
// ----------------------------------------------------------------------------
module gsig_checker
    import gsig_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic cmd,
    input logic done
);

    logic map_acc;

    assign map_acc = start && !busy && (cmd == CMD_MAP) && rst_n;

    a_never_busy : assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_map_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
        map_acc |-> ##LATENCY done)
        else $error("map transaction gave no result");

    a_result_has_map : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(map_acc, LATENCY))
        else $error("result without a map transaction");

endmodule

bind gather_source_index_generator_top gsig_checker u_gsig_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done)
);

### tb/gather_row_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gather row checker
// Watches the command, configuration and result ports of the gather source
// index generator, predicts each source row and compares it in order.
// ----------------------------------------------------------------------------
module gather_row_checker
    import gsig_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        cmd,
    input  logic [31:0] out_row,
    input  logic [1:0]  table_sel,
    input  logic [9:0]  entry_pos,
    input  logic [31:0] entry_value,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        done,
    input  logic [31:0] source_row,
    output int          mismatch_count,
    output int          pending_count
);

    localparam int TABLE_DEPTH = 1024;
    localparam int EXP_DEPTH   = 64;

    gsig_cfg_t   cfg;
    logic [31:0] gather_table [4][TABLE_DEPTH];
    logic [31:0] expected_rows [0:EXP_DEPTH-1];
    int          wr_count;
    int          rd_count;

    // Expected rows sit in a ring; the counters only ever grow.
    assign pending_count = wr_count - rd_count;

    function automatic logic [31:0] predict_source_row(input logic [31:0] row_in);
        logic [31:0] row;
        logic [31:0] acc;
        logic [31:0] pos;
        logic [31:0] coord;
        logic [31:0] stride;
        logic [15:0] osz;
        logic        first;
        int          odim;
        int          od;
        int          rf;
        int          rl;
        row   = row_in;
        acc   = '0;
        pos   = '0;
        first = 1'b1;
        odim  = 3;
        rf    = int'($signed(cfg.range_first));
        rl    = int'($signed(cfg.range_last));
        for (int dim = 3; dim >= 0; dim--)
        begin
            od     = (odim < 0) ? 0 : odim;
            osz    = cfg.out_sizes[16*od +: 16];
            stride = (dim < 2) ? cfg.strides_outer[32*dim +: 32]
                               : cfg.strides_inner[32*(dim-2) +: 32];
            if (cfg.indexed_mask[dim])
            begin
                // The shared entry position is fixed at the first indexed dimension.
                if (first)
                    pos = (cfg.index_length == 0) ? row : row % 32'(cfg.index_length);
                coord = (pos < TABLE_DEPTH) ? gather_table[dim][pos[9:0]] : '0;
                if (coord[31])
                    coord = coord + 32'(cfg.in_sizes[16*dim +: 16]);
                acc = acc + coord * stride;
                if (first)
                    row = (osz == 0) ? '1 : row / 32'(osz);
                first = 1'b0;
            end
            else
            begin
                acc = acc + ((osz == 0) ? row : row % 32'(osz)) * stride;
                row = (osz == 0) ? '1 : row / 32'(osz);
            end
            if (!(rf < dim && dim <= rl))
                odim--;
        end
        return acc;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.out_sizes     <= 64'd281479271743489;
            cfg.in_sizes      <= 64'd281479271743489;
            cfg.strides_outer <= '0;
            cfg.strides_inner <= '0;
            cfg.indexed_mask  <= '0;
            cfg.index_length  <= 11'd1;
            cfg.range_first   <= 4'hF;
            cfg.range_last    <= 4'hF;
            mismatch_count    <= 0;
            wr_count          <= 0;
            rd_count          <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_OUT_SIZES:     cfg.out_sizes     <= cfg_data;
                    REG_IN_SIZES:      cfg.in_sizes      <= cfg_data;
                    REG_STRIDES_OUTER: cfg.strides_outer <= cfg_data;
                    REG_STRIDES_INNER: cfg.strides_inner <= cfg_data;
                    REG_INDEXED_MASK:  cfg.indexed_mask  <= cfg_data[3:0];
                    REG_INDEX_LENGTH:  cfg.index_length  <= cfg_data[10:0];
                    REG_RANGE_FIRST:   cfg.range_first   <= cfg_data[3:0];
                    REG_RANGE_LAST:    cfg.range_last    <= cfg_data[3:0];
                    default: ;
                endcase
            end
            // Loads and maps are predicted in acceptance order, which is the
            // order in which the block applies them to its tables.
            if (start && !busy)
            begin
                if (cmd == CMD_LOAD)
                    gather_table[table_sel][entry_pos] = entry_value;
                else
                begin
                    expected_rows[6'(wr_count)] <= predict_source_row(out_row);
                    wr_count <= wr_count + 1;
                end
            end
            if (done)
            begin
                if (wr_count == rd_count)
                begin
                    $display("%0t: unexpected source_row %h", $time, source_row);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    if (expected_rows[6'(rd_count)] !== source_row)
                    begin
                        $display("%0t: source_row expected %h actual %h",
                                 $time, expected_rows[6'(rd_count)], source_row);
                        mismatch_count <= mismatch_count + 1;
                    end
                    rd_count <= rd_count + 1;
                end
            end
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gather source index generator testbench
// Fills the low part of the index tables, then runs directed and random map
// and load transactions through a series of register settings, with random
// idle bursts, and reports whether the checker saw any mismatch.
// ----------------------------------------------------------------------------
module tb;
    import gsig_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_ITEMS    = 80;
    localparam int FILL_DEPTH     = 256;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        cmd = CMD_MAP;
    logic [31:0] out_row = '0;
    logic [1:0]  table_sel = '0;
    logic [9:0]  entry_pos = '0;
    logic [31:0] entry_value = '0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_OUT_SIZES;
    logic [63:0] cfg_data = '0;
    logic        done;
    logic [31:0] source_row;
    int          mismatch_count;
    int          pending_count;
    int          idle_cycles = 0;
    bit          allow_idle = 1'b1;

    // The clock runs at 100 MHz.
    always #5 clk = ~clk;

    gather_source_index_generator_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .out_row     (out_row),
        .table_sel   (table_sel),
        .entry_pos   (entry_pos),
        .entry_value (entry_value),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .source_row  (source_row)
    );

    gather_row_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .out_row        (out_row),
        .table_sel      (table_sel),
        .entry_pos      (entry_pos),
        .entry_value    (entry_value),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .source_row     (source_row),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // The watchdog counts cycles in which neither a transaction is accepted
    // nor a result comes out; a hang stops the run with a failure.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Presents one transaction from a falling edge and holds it until a
    // rising edge with busy low takes it. An idle burst may come first.
    task automatic issue(input logic is_load, input logic [31:0] row,
                         input logic [1:0] sel, input logic [9:0] pos,
                         input logic [31:0] value);
        if (allow_idle && $urandom_range(0, 7) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        start       = 1'b1;
        cmd         = is_load;
        out_row     = row;
        table_sel   = sel;
        entry_pos   = pos;
        entry_value = value;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        @(negedge clk);
    endtask

    task automatic map_row(input logic [31:0] row);
        issue(CMD_MAP, row, 2'($urandom), 10'($urandom), $urandom);
    endtask

    task automatic load_entry(input logic [1:0] sel, input logic [9:0] pos,
                              input logic [31:0] value);
        issue(CMD_LOAD, $urandom, sel, pos, value);
    endtask

    // Waits until every expected result has arrived, then lets the pipeline
    // drain any loads still in flight before the registers may change.
    task automatic drain();
        start = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [63:0] random_sizes();
        logic [63:0] v;
        for (int d = 0; d < 4; d++)
        begin
            case ($urandom_range(0, 9))
                0:       v[16*d +: 16] = 16'hFFFF;
                1:       v[16*d +: 16] = 16'($urandom);
                2:       v[16*d +: 16] = 16'h0;
                default: v[16*d +: 16] = 16'($urandom_range(1, 9));
            endcase
        end
        return v;
    endfunction

    function automatic logic [63:0] random_strides();
        if ($urandom_range(0, 1) == 0)
            return {$urandom, $urandom};
        return {32'($urandom_range(0, 4096)), 32'($urandom_range(0, 4096))};
    endfunction

    // Random lengths keep the shared position inside the filled entries.
    function automatic logic [63:0] random_length();
        case ($urandom_range(0, 4))
            0:       return 64'd1;
            1:       return 64'(FILL_DEPTH);
            2:       return 64'($urandom_range(1, FILL_DEPTH));
            default: return 64'($urandom_range(1, 16));
        endcase
    endfunction

    // Phase one drives every register to its top value, except the index
    // length, which stays at the filled part of the tables. Phase two drives
    // the sizes, length and range start to the bottom: zero sizes and length
    // exercise the divide-by-zero rule, and since the zero output size turns
    // the row into all ones before the first indexed dimension, the shared
    // position lands past the table depth. The rest pick random settings.
    task automatic apply_setting(input int phase);
        case (phase)
            1:
            begin
                write_reg(REG_OUT_SIZES, '1);
                write_reg(REG_IN_SIZES, '1);
                write_reg(REG_STRIDES_OUTER, '1);
                write_reg(REG_STRIDES_INNER, '1);
                write_reg(REG_INDEXED_MASK, 64'hF);
                write_reg(REG_INDEX_LENGTH, 64'(FILL_DEPTH));
                write_reg(REG_RANGE_FIRST, 64'h7);
                write_reg(REG_RANGE_LAST, 64'h7);
            end
            2:
            begin
                write_reg(REG_OUT_SIZES, '0);
                write_reg(REG_IN_SIZES, '0);
                write_reg(REG_STRIDES_OUTER, 64'h0000_0003_0000_0001);
                write_reg(REG_STRIDES_INNER, 64'h0000_0007_0000_0005);
                write_reg(REG_INDEXED_MASK, 64'h5);
                write_reg(REG_INDEX_LENGTH, '0);
                write_reg(REG_RANGE_FIRST, 64'h8);
                write_reg(REG_RANGE_LAST, 64'h7);
            end
            default:
            begin
                write_reg(REG_OUT_SIZES, random_sizes());
                write_reg(REG_IN_SIZES, {$urandom, $urandom});
                write_reg(REG_STRIDES_OUTER, random_strides());
                write_reg(REG_STRIDES_INNER, random_strides());
                write_reg(REG_INDEXED_MASK, 64'($urandom_range(0, 15)));
                write_reg(REG_INDEX_LENGTH, random_length());
                // Most random ranges fall in the legal window; some do not.
                if ($urandom_range(0, 3) == 0)
                begin
                    write_reg(REG_RANGE_FIRST, 64'($urandom_range(0, 15)));
                    write_reg(REG_RANGE_LAST, 64'($urandom_range(0, 15)));
                end
                else
                begin
                    write_reg(REG_RANGE_FIRST, 64'(4'($signed($urandom_range(0, 5)) - 1)));
                    write_reg(REG_RANGE_LAST, 64'(4'($signed($urandom_range(0, 5)) - 1)));
                end
            end
        endcase
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // The low FILL_DEPTH entries of every table are written before any
        // map runs, since the tables come out of reset undefined. Every
        // index length set later keeps the shared position inside them or
        // past the table depth.
        for (int sel = 0; sel < 4; sel++)
            for (int pos = 0; pos < FILL_DEPTH; pos++)
                load_entry(2'(sel), 10'(pos), $urandom);

        // Directed transactions under the reset setting: row extremes and
        // the sign-bit and full-scale entry values.
        map_row(32'h0);
        map_row(32'h1);
        map_row(32'hFFFF_FFFF);
        map_row(32'h8000_0000);
        load_entry(2'd3, 10'd0, 32'h8000_0000);
        load_entry(2'd0, 10'd1023, 32'h7FFF_FFFF);
        load_entry(2'd1, 10'd0, 32'hFFFF_FFFF);
        load_entry(2'd2, 10'd0, 32'h0);

        for (int phase = 1; phase <= NUM_PHASES; phase++)
        begin
            drain();
            apply_setting(phase);
            if (phase <= 2)
            begin
                // Extreme settings with all-indexed and divide-by-zero paths.
                map_row(32'h0);
                map_row(32'hFFFF_FFFF);
                map_row(32'h8000_0000);
                map_row(32'd1023);
                map_row(32'd1024);
                map_row(32'd2047);
            end
            // The final phases run back to back with no idle bursts.
            allow_idle = (phase < NUM_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Midway through one phase the source holds off until every
                // expected result has come back.
                if (phase == 4 && n == PHASE_ITEMS / 2)
                begin
                    start = 1'b0;
                    while (pending_count != 0)
                        @(negedge clk);
                end
                if ($urandom_range(0, 3) == 0)
                    load_entry(2'($urandom), 10'($urandom), $urandom);
                else if ($urandom_range(0, 1) == 0)
                    map_row($urandom_range(0, 4095));
                else
                    map_row($urandom);
            end
        end

        start = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);

        if (mismatch_count == 0 && pending_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
